>>> hdl/nwpr_pkg.sv
`timescale 1ns / 1ps

package nwpr_pkg;

    // Sample and accumulator widths
    localparam int SampleBits  = 16;
    localparam int SumBits     = 22;
    localparam int WideBits    = 38;
    localparam int RatioBits   = 27;
    localparam int MagBits     = 28;
    localparam int NbpBits     = 45;
    localparam int DivBits     = NbpBits + 16;
    localparam int LogBits     = 21;

    // Register limits and reset values
    localparam logic [6:0]  MinBlockLen   = 7'd2;
    localparam logic [6:0]  MaxBlockLen   = 7'd64;
    localparam logic [4:0]  MinBlocks     = 5'd1;
    localparam logic [4:0]  MaxBlocks     = 5'd16;
    localparam logic [6:0]  RstBlockLen   = 7'd20;
    localparam logic [4:0]  RstBlockCnt   = 5'd10;
    localparam logic [15:0] RstPeriodOffs = 16'd7680;

    // Register indexes on the configuration port
    localparam logic [1:0] RegBlockLen  = 2'd0;
    localparam logic [1:0] RegBlockCnt  = 2'd1;
    localparam logic [1:0] RegPeriodOff = 2'd2;

    // Status codes
    localparam logic [1:0] StatValid     = 2'd0;
    localparam logic [1:0] StatZeroPower = 2'd1;
    localparam logic [1:0] StatUndefined = 2'd2;

    // 10*log10(2) in Q16
    localparam logic signed [18:0] DbPerLog2 = 19'sd197283;

    // One closed block handed from front to back
    typedef struct packed {
        logic [WideBits-1:0] wide;
        logic [SumBits-1:0]  isum;
        logic [SumBits-1:0]  qsum;
        logic                last;
        logic [6:0]          m_len;
        logic [4:0]          k_cnt;
        logic [15:0]         offset;
    } blk_entry_t;

    // Position of the highest set bit
    function automatic logic [4:0] msb_pos(input logic [MagBits-1:0] x);
        logic [4:0] p;
        p = 5'd0;
        for (int b = 0; b < MagBits; b++)
        begin
            if (x[b])
            begin
                p = 5'(b);
            end
        end
        return p;
    endfunction

endpackage

>>> hdl/nwpr_cn0_estimator.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat
// s_axis    in         tdata = i_sample, q_sample
// m_axis    out        tdata = cn0_db, tuser = status; one beat per K blocks
// apb       in/out     block_length @0, block_count @4, period_offset_db @8
//
// The front takes a new sample only once the last is folded in (two squares
// on one multiplier). Each closed block passes the back's 61-step bit-serial
// divider (a silent block skips it); an estimate then adds the two logs and
// the rounding, unless a special case applies.
// A two-entry block queue lets the front run on while the back divides;
// the front stalls only when the queue is full at a block end.
// Reset clears all accumulators and restores the register defaults.

module nwpr_cn0_estimator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] i_sample, [31:16] q_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] cn0_db
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]  blen_reg;
    logic [4:0]  bcnt_reg;
    logic [15:0] poff_reg;
    logic [6:0]  m_len;
    logic [4:0]  k_cnt;
    logic        push, full, pop, empty;
    nwpr_pkg::blk_entry_t push_data, pop_data;

    assign pready = 1'b1;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blen_reg <= nwpr_pkg::RstBlockLen;
            bcnt_reg <= nwpr_pkg::RstBlockCnt;
            poff_reg <= nwpr_pkg::RstPeriodOffs;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                nwpr_pkg::RegBlockLen:  blen_reg <= pwdata[6:0];
                nwpr_pkg::RegBlockCnt:  bcnt_reg <= pwdata[4:0];
                nwpr_pkg::RegPeriodOff: poff_reg <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            nwpr_pkg::RegBlockLen:  prdata = {25'd0, blen_reg};
            nwpr_pkg::RegBlockCnt:  prdata = {27'd0, bcnt_reg};
            nwpr_pkg::RegPeriodOff: prdata = {16'd0, poff_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // Clamp M and K to their working ranges
    assign m_len = (blen_reg < nwpr_pkg::MinBlockLen) ? nwpr_pkg::MinBlockLen :
                   (blen_reg > nwpr_pkg::MaxBlockLen) ? nwpr_pkg::MaxBlockLen : blen_reg;
    assign k_cnt = (bcnt_reg < nwpr_pkg::MinBlocks) ? nwpr_pkg::MinBlocks :
                   (bcnt_reg > nwpr_pkg::MaxBlocks) ? nwpr_pkg::MaxBlocks : bcnt_reg;

    nwpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .i_sample  (s_axis_tdata[15:0]),
        .q_sample  (s_axis_tdata[31:16]),
        .m_len     (m_len),
        .k_cnt     (k_cnt),
        .offset    (poff_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    nwpr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    nwpr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .cn0_db   (m_axis_tdata),
        .status   (m_axis_tuser)
    );

endmodule

>>> hdl/nwpr_fifo.sv
`timescale 1ns / 1ps

module nwpr_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  nwpr_pkg::blk_entry_t push_data,
    output logic                 full,
    input  logic                 pop,
    output nwpr_pkg::blk_entry_t pop_data,
    output logic                 empty
);

    nwpr_pkg::blk_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/nwpr_front.sv
`timescale 1ns / 1ps

module nwpr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [15:0]          i_sample,
    input  logic [15:0]          q_sample,
    input  logic [6:0]           m_len,
    input  logic [4:0]           k_cnt,
    input  logic [15:0]          offset,
    output logic                 push,
    output nwpr_pkg::blk_entry_t push_data,
    input  logic                 full
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_SQI  = 4'b0010,
        F_SQQ  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic signed [15:0] i_reg, q_reg;
    logic [nwpr_pkg::WideBits-1:0] wide_reg, wide_next;
    logic signed [nwpr_pkg::SumBits-1:0] isum_reg, isum_next;
    logic signed [nwpr_pkg::SumBits-1:0] qsum_reg, qsum_next;
    logic [5:0] sidx_reg, sidx_next;
    logic [3:0] bidx_reg, bidx_next;
    logic signed [31:0] sq;
    logic blk_end, est_end;

    assign s_ready = (state_reg == F_IDLE);
    assign blk_end = ({1'b0, sidx_reg} + 7'd1) >= m_len;
    assign est_end = ({1'b0, bidx_reg} + 5'd1) >= k_cnt;
    assign sq      = (state_reg == F_SQI) ? i_reg * i_reg : q_reg * q_reg;

    assign push_data.wide   = wide_reg;
    assign push_data.isum   = isum_reg;
    assign push_data.qsum   = qsum_reg;
    assign push_data.last   = est_end;
    assign push_data.m_len  = m_len;
    assign push_data.k_cnt  = k_cnt;
    assign push_data.offset = offset;

    // Accumulate one sample, close the block when M is reached
    always_comb
    begin
        state_next = state_reg;
        wide_next  = wide_reg;
        isum_next  = isum_reg;
        qsum_next  = qsum_reg;
        sidx_next  = sidx_reg;
        bidx_next  = bidx_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = F_SQI;
                end
            end
            F_SQI:
            begin
                wide_next  = wide_reg + {6'd0, sq};
                state_next = F_SQQ;
            end
            F_SQQ:
            begin
                wide_next  = wide_reg + {6'd0, sq};
                isum_next  = isum_reg + nwpr_pkg::SumBits'(i_reg);
                qsum_next  = qsum_reg + nwpr_pkg::SumBits'(q_reg);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!blk_end)
                begin
                    sidx_next  = sidx_reg + 6'd1;
                    state_next = F_IDLE;
                end
                else if (!full)
                begin
                    push       = 1'b1;
                    wide_next  = '0;
                    isum_next  = '0;
                    qsum_next  = '0;
                    sidx_next  = 6'd0;
                    bidx_next  = est_end ? 4'd0 : bidx_reg + 4'd1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            wide_reg  <= '0;
            isum_reg  <= '0;
            qsum_reg  <= '0;
            sidx_reg  <= 6'd0;
            bidx_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            wide_reg  <= wide_next;
            isum_reg  <= isum_next;
            qsum_reg  <= qsum_next;
            sidx_reg  <= sidx_next;
            bidx_reg  <= bidx_next;
        end
    end

    // Hold the accepted beat
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            i_reg <= i_sample;
            q_reg <= q_sample;
        end
    end

endmodule

>>> hdl/nwpr_back.sv
`timescale 1ns / 1ps

module nwpr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  nwpr_pkg::blk_entry_t pop_data,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          cn0_db,
    output logic [1:0]           status
);

    typedef enum logic [10:0] {
        B_IDLE  = 11'b00000000001,
        B_SQI   = 11'b00000000010,
        B_SQQ   = 11'b00000000100,
        B_DIV   = 11'b00000001000,
        B_ACC   = 11'b00000010000,
        B_EST   = 11'b00000100000,
        B_LPREP = 11'b00001000000,
        B_LOG   = 11'b00010000000,
        B_SCALE = 11'b00100000000,
        B_FIN   = 11'b01000000000,
        B_DONE  = 11'b10000000000
    } back_state_t;

    localparam int MagBits = nwpr_pkg::MagBits;
    localparam int DivBits = nwpr_pkg::DivBits;
    localparam int LogBits = nwpr_pkg::LogBits;

    back_state_t state_reg, state_next;

    nwpr_pkg::blk_entry_t ent_reg;
    logic [nwpr_pkg::NbpBits-1:0]     nbp_reg, nbp_next;
    logic [DivBits-1:0]               dq_reg, dq_next;
    logic [nwpr_pkg::WideBits-1:0]    rem_reg, rem_next;
    logic [5:0]                       cnt_reg, cnt_next;
    logic [nwpr_pkg::RatioBits-1:0]   ratio_reg, ratio_next;
    logic                             zero_reg, zero_next;
    logic [MagBits-1:0]               an_reg, an_next, ad_reg, ad_next;
    logic                             sel_reg, sel_next;
    logic [4:0]                       n_reg, n_next;
    logic [30:0]                      mant_reg, mant_next;
    logic [15:0]                      frac_reg, frac_next;
    logic [LogBits-1:0]               ln_reg, ln_next;
    logic signed [40:0]               prod_reg, prod_next;
    logic                             ov_reg, ov_next;
    logic [15:0]                      db_reg, db_next;
    logic [1:0]                       st_reg, st_next;

    logic signed [43:0]               sq;
    logic [nwpr_pkg::WideBits:0]      rem_sh;
    logic [11:0]                      mk;
    logic signed [28:0]               num, den;
    logic [MagBits-1:0]               xsel;
    logic [4:0]                       xpos;
    logic [61:0]                      msq;
    logic [31:0]                      mt;
    logic signed [LogBits:0]          dlog;
    logic signed [41:0]               rnd;
    logic signed [18:0]               total;

    assign m_valid = ov_reg;
    assign cn0_db  = db_reg;
    assign status  = st_reg;
    assign pop     = (state_reg == B_IDLE) && !empty;

    // Shared datapath pieces
    assign sq     = (state_reg == B_SQI) ? $signed(ent_reg.isum) * $signed(ent_reg.isum)
                                         : $signed(ent_reg.qsum) * $signed(ent_reg.qsum);
    assign rem_sh = {rem_reg, dq_reg[DivBits-1]};
    assign mk     = 12'(ent_reg.m_len) * 12'(ent_reg.k_cnt);
    assign num    = $signed({2'b00, ratio_reg}) - $signed({8'd0, ent_reg.k_cnt, 16'd0});
    assign den    = $signed({1'b0, mk, 16'd0}) - $signed({2'b00, ratio_reg});
    assign xsel   = sel_reg ? ad_reg : an_reg;
    assign xpos   = nwpr_pkg::msb_pos(xsel);
    assign msq    = {31'd0, mant_reg} * {31'd0, mant_reg};
    assign mt     = msq[61:30];
    assign dlog   = $signed({1'b0, ln_reg}) - $signed({1'b0, n_reg, frac_reg});
    assign rnd    = 42'(prod_reg) + 42'sd8388608;
    assign total  = 19'(rnd >>> 24) + 19'($signed(ent_reg.offset));

    always_comb
    begin
        state_next = state_reg;
        nbp_next   = nbp_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        ratio_next = ratio_reg;
        zero_next  = zero_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        sel_next   = sel_reg;
        n_next     = n_reg;
        mant_next  = mant_reg;
        frac_next  = frac_reg;
        ln_next    = ln_reg;
        prod_next  = prod_reg;
        ov_next    = ov_reg;
        db_next    = db_reg;
        st_next    = st_reg;
        if (ov_reg && m_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            // Take a closed block; a silent block only marks the estimate
            B_IDLE:
            begin
                if (!empty)
                begin
                    if (pop_data.wide == '0)
                    begin
                        zero_next  = 1'b1;
                        dq_next    = '0;
                        state_next = B_ACC;
                    end
                    else
                    begin
                        state_next = B_SQI;
                    end
                end
            end
            B_SQI:
            begin
                nbp_next   = {1'b0, 44'(sq)};
                state_next = B_SQQ;
            end
            B_SQQ:
            begin
                dq_next    = {nbp_reg + {1'b0, 44'(sq)}, 16'd0};
                rem_next   = '0;
                cnt_next   = 6'(DivBits - 1);
                state_next = B_DIV;
            end
            // Restoring division, one quotient bit a cycle
            B_DIV:
            begin
                if (rem_sh >= {1'b0, ent_reg.wide})
                begin
                    rem_next = nwpr_pkg::WideBits'(rem_sh - {1'b0, ent_reg.wide});
                    dq_next  = {dq_reg[DivBits-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[nwpr_pkg::WideBits-1:0];
                    dq_next  = {dq_reg[DivBits-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = B_ACC;
                end
            end
            B_ACC:
            begin
                ratio_next = ratio_reg + dq_reg[nwpr_pkg::RatioBits-1:0];
                state_next = ent_reg.last ? B_EST : B_IDLE;
            end
            // Close the estimate: special cases or start the logs
            B_EST:
            begin
                if (!ov_reg)
                begin
                    if (zero_reg)
                    begin
                        db_next    = 16'd0;
                        st_next    = nwpr_pkg::StatZeroPower;
                        state_next = B_DONE;
                    end
                    else if (num == '0)
                    begin
                        db_next    = 16'h8000;
                        st_next    = nwpr_pkg::StatUndefined;
                        state_next = B_DONE;
                    end
                    else if (den == '0)
                    begin
                        db_next    = 16'h7FFF;
                        st_next    = nwpr_pkg::StatUndefined;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        an_next    = MagBits'(num[28] ? -num : num);
                        ad_next    = MagBits'(den[28] ? -den : den);
                        sel_next   = 1'b0;
                        state_next = B_LPREP;
                    end
                end
            end
            // Normalise the mantissa to Q30
            B_LPREP:
            begin
                n_next     = xpos;
                mant_next  = 31'({3'd0, xsel} << (5'd30 - xpos));
                frac_next  = 16'd0;
                cnt_next   = 6'd15;
                state_next = B_LOG;
            end
            // One fraction bit a cycle by squaring
            B_LOG:
            begin
                if (mt[31])
                begin
                    mant_next = mt[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    mant_next = mt[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    if (!sel_reg)
                    begin
                        ln_next    = {n_reg, frac_next};
                        sel_next   = 1'b1;
                        state_next = B_LPREP;
                    end
                    else
                    begin
                        frac_next  = frac_next;
                        state_next = B_SCALE;
                    end
                end
            end
            B_SCALE:
            begin
                prod_next  = dlog * nwpr_pkg::DbPerLog2;
                state_next = B_FIN;
            end
            // Round, add the period offset and saturate
            B_FIN:
            begin
                if (total > 19'sd32767)
                begin
                    db_next = 16'h7FFF;
                end
                else if (total < -19'sd32768)
                begin
                    db_next = 16'h8000;
                end
                else
                begin
                    db_next = total[15:0];
                end
                st_next    = nwpr_pkg::StatValid;
                state_next = B_DONE;
            end
            B_DONE:
            begin
                ov_next    = 1'b1;
                ratio_next = '0;
                zero_next  = 1'b0;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ratio_reg <= '0;
            zero_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            cnt_reg   <= 6'd0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ratio_reg <= ratio_next;
            zero_reg  <= zero_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= pop_data;
        end
        nbp_reg  <= nbp_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        n_reg    <= n_next;
        mant_reg <= mant_next;
        frac_reg <= frac_next;
        ln_reg   <= ln_next;
        prod_reg <= prod_next;
        db_reg   <= db_next;
        st_reg   <= st_next;
    end

endmodule

>>> sim/nwpr_cn0_estimator_tb.sv
`timescale 1ns / 1ps

module nwpr_cn0_estimator_tb;

    typedef struct {
        logic [15:0] cn0;
        logic [1:0]  stat;
    } cn0_result_t;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copies and estimator state of the predictor
    logic [6:0]  cfg_len = nwpr_pkg::RstBlockLen;
    logic [4:0]  cfg_cnt = nwpr_pkg::RstBlockCnt;
    logic [15:0] cfg_offs = nwpr_pkg::RstPeriodOffs;
    longint unsigned wide_sum;
    longint          i_sum;
    longint          q_sum;
    longint unsigned ratio_sum;
    int              samp_idx;
    int              blk_idx;
    bit              zero_blk;

    logic [31:0] sample_q[$];
    cn0_result_t cn0_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          sent = 0;
    bit          idle_en = 1'b1;
    int          in_gap = 0;
    int          out_gap = 0;
    int          hold_left = 0;
    int          hold_req = 0;
    int          hold_seen = 0;

    nwpr_cn0_estimator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] i_sample, [31:16] q_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] cn0_db
        .m_axis_tuser  (m_axis_tuser),   // [1:0] status
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // log2 in unsigned Q16 by repeated squaring of the mantissa
    function automatic longint log2_q16(input longint unsigned x);
        int              n;
        longint unsigned m;
        longint unsigned f;
        n = 63;
        f = 0;
        while (n > 0 && x[n] == 1'b0)
            n--;
        if (n > 30)
            m = x >> (n - 30);
        else
            m = x << (30 - n);
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= 64'd2147483648)
            begin
                f = f | 1;
                m = m >> 1;
            end
        end
        return (longint'(n) <<< 16) | longint'(f);
    endfunction

    function automatic logic [15:0] sat16(input int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    function automatic void clear_estimate();
        wide_sum = 0;
        i_sum = 0;
        q_sum = 0;
        ratio_sum = 0;
        samp_idx = 0;
        blk_idx = 0;
        zero_blk = 1'b0;
    endfunction

    // Fold one accepted sample into the estimate; queue a result at its end
    function automatic void absorb_sample(input logic [31:0] d);
        longint          iv;
        longint          qv;
        longint unsigned nbp;
        longint          m_len;
        longint          k_cnt;
        longint          num;
        longint          den;
        longint          dlog;
        longint          total;
        cn0_result_t     r;
        m_len = (cfg_len < nwpr_pkg::MinBlockLen) ? nwpr_pkg::MinBlockLen :
                (cfg_len > nwpr_pkg::MaxBlockLen) ? nwpr_pkg::MaxBlockLen : cfg_len;
        k_cnt = (cfg_cnt < nwpr_pkg::MinBlocks) ? nwpr_pkg::MinBlocks :
                (cfg_cnt > nwpr_pkg::MaxBlocks) ? nwpr_pkg::MaxBlocks : cfg_cnt;
        iv = longint'($signed(d[15:0]));
        qv = longint'($signed(d[31:16]));
        wide_sum += longint'(iv * iv + qv * qv);
        i_sum += iv;
        q_sum += qv;
        samp_idx++;
        if (samp_idx < m_len)
            return;
        if (wide_sum == 0)
            zero_blk = 1'b1;
        else
        begin
            nbp = i_sum * i_sum + q_sum * q_sum;
            ratio_sum += (nbp << 16) / wide_sum;
        end
        wide_sum = 0;
        i_sum = 0;
        q_sum = 0;
        samp_idx = 0;
        blk_idx++;
        if (blk_idx < k_cnt)
            return;
        num = longint'(ratio_sum) - k_cnt * 65536;
        den = m_len * k_cnt * 65536 - longint'(ratio_sum);
        if (zero_blk)
        begin
            r.cn0 = 16'd0;
            r.stat = nwpr_pkg::StatZeroPower;
        end
        else if (num == 0)
        begin
            r.cn0 = 16'h8000;
            r.stat = nwpr_pkg::StatUndefined;
        end
        else if (den == 0)
        begin
            r.cn0 = 16'h7FFF;
            r.stat = nwpr_pkg::StatUndefined;
        end
        else
        begin
            if (num < 0)
                num = -num;
            if (den < 0)
                den = -den;
            dlog = log2_q16(num) - log2_q16(den);
            total = ((dlog * longint'(nwpr_pkg::DbPerLog2)) + 64'sd8388608) >>> 24;
            total = total + longint'($signed(cfg_offs));
            r.cn0 = sat16(int'(total > 40000 ? 40000 : total < -40000 ? -40000 : total));
            r.stat = nwpr_pkg::StatValid;
        end
        cn0_q.push_back(r);
        clear_estimate();
    endfunction

    // Drive sample beats from the pending queue with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            clear_estimate();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_sample(s_axis_tdata);
                sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    s_axis_tdata <= sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (idle_en && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 5);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Count down a long output hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Check result beats and stall the output at random
    always @(posedge clk or negedge rst_n)
    begin
        cn0_result_t e;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cn0_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result cn0 %h status %0d",
                                 m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    e = cn0_q.pop_front();
                    if (m_axis_tdata !== e.cn0 || m_axis_tuser !== e.stat)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: cn0 exp %h got %h, status exp %0d got %0d",
                                     e.cn0, m_axis_tdata, e.stat, m_axis_tuser);
                    end
                end
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (idle_en && $urandom_range(0, 5) == 0)
                    out_gap = $urandom_range(1, 5);
            end
        end
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            nwpr_pkg::RegBlockLen:  cfg_len = val[6:0];
            nwpr_pkg::RegBlockCnt:  cfg_cnt = val[4:0];
            nwpr_pkg::RegPeriodOff: cfg_offs = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int len, input int cnt, input int offs);
        write_reg(nwpr_pkg::RegBlockLen, 32'(len));
        write_reg(nwpr_pkg::RegBlockCnt, 32'(cnt));
        write_reg(nwpr_pkg::RegPeriodOff, 32'(offs));
    endtask

    // Hold until every sample is in and every estimate is out, then drain
    task automatic wait_quiet();
        while (sample_q.size() > 0 || s_axis_tvalid || cn0_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pack_iq(input int iv, input int qv);
        return {sat16(qv), sat16(iv)};
    endfunction

    // Queue whole estimates with a chosen sample style
    task automatic queue_estimates(input int n_est);
        int m_len;
        int k_cnt;
        int style;
        int amp_i;
        int amp_q;
        int noise;
        m_len = (cfg_len < 2) ? 2 : (cfg_len > 64) ? 64 : cfg_len;
        k_cnt = (cfg_cnt < 1) ? 1 : (cfg_cnt > 16) ? 16 : cfg_cnt;
        for (int e = 0; e < n_est; e++)
        begin
            style = $urandom_range(0, 9);
            amp_i = int'($signed(16'($urandom)));
            amp_q = int'($signed(16'($urandom))) >>> $urandom_range(0, 15);
            noise = 1 << $urandom_range(0, 14);
            for (int s = 0; s < m_len * k_cnt; s++)
            begin
                if (style < 2)
                    sample_q.push_back($urandom);
                else if (style < 8)
                    sample_q.push_back(pack_iq(
                        amp_i + $urandom_range(0, 2 * noise) - noise,
                        amp_q + $urandom_range(0, 2 * noise) - noise));
                else if (style == 8)
                    sample_q.push_back(pack_iq($urandom_range(0, 4) - 2,
                                               $urandom_range(0, 4) - 2));
                else if (s < m_len)
                    sample_q.push_back(32'd0);
                else
                    sample_q.push_back($urandom);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: two-sample blocks, one block per estimate
        set_config(2, 1, 0);
        // zero wideband power
        sample_q.push_back(pack_iq(0, 0));
        sample_q.push_back(pack_iq(0, 0));
        // zero ratio numerator: mean ratio of one
        sample_q.push_back(pack_iq(1, 0));
        sample_q.push_back(pack_iq(0, 1));
        // zero denominator: mean ratio equal to block length
        sample_q.push_back(pack_iq(1, 0));
        sample_q.push_back(pack_iq(1, 0));
        // full-scale extremes
        sample_q.push_back(pack_iq(-32768, -32768));
        sample_q.push_back(pack_iq(32767, 32767));
        sample_q.push_back(pack_iq(-32768, 32767));
        sample_q.push_back(pack_iq(-32768, 32767));
        sample_q.push_back(pack_iq(32767, -32768));
        sample_q.push_back(pack_iq(-1, -1));
        sample_q.push_back(pack_iq(1, 0));
        sample_q.push_back(pack_iq(-1, 0));
        wait_quiet();
        // saturate high and low through the offset
        write_reg(nwpr_pkg::RegPeriodOff, 32'h7FFF);
        sample_q.push_back(pack_iq(1000, 5));
        sample_q.push_back(pack_iq(1000, -3));
        wait_quiet();
        write_reg(nwpr_pkg::RegPeriodOff, 32'h8000);
        sample_q.push_back(pack_iq(1000, 5));
        sample_q.push_back(pack_iq(-7, 900));
        wait_quiet();

        // Register extremes, in and out of range
        set_config(64, 1, 32767);
        queue_estimates(1);
        wait_quiet();
        set_config(2, 16, -32768);
        queue_estimates(2);
        wait_quiet();
        set_config(0, 0, 32'hFFFF_1234);
        queue_estimates(3);
        wait_quiet();
        set_config(100, 2, 7680);
        queue_estimates(1);
        wait_quiet();
        set_config(3, 31, 32'h0000_FF00);
        queue_estimates(1);
        wait_quiet();

        // Back-pressure: output held off while short estimates pile up
        set_config(2, 1, $urandom);
        hold_req++;
        queue_estimates(30);
        wait_quiet();

        // Random settings, no idling near the end
        while (sent < 750)
        begin
            if (sent > 600)
                idle_en = 1'b0;
            set_config($urandom_range(2, 12), $urandom_range(1, 4), $urandom);
            queue_estimates($urandom_range(1, 3));
            wait_quiet();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hdl/nwpr_pkg.sv
hdl/nwpr_fifo.sv
hdl/nwpr_front.sv
hdl/nwpr_back.sv
hdl/nwpr_cn0_estimator.sv
sim/nwpr_cn0_estimator_tb.sv
